// File: sv/pclb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pclb_pkg;

  localparam int MAX_AXIS_CELLS = 16;
  localparam int AXIS_W = 4;
  localparam int N_W = 5;
  localparam int CELL_W = 12;
  localparam int NUM_CELLS = 4096;
  localparam int ACTIVE_W = 13;
  localparam int LEN_W = 31;
  localparam int DIV_W = 36;
  localparam int DIV_CNT_W = 6;
  localparam int OUT_IDS = 8;

  localparam logic [N_W-1:0] WIDE_AXIS = 5'd4;

  localparam logic [2:0] REG_LEN_X   = 3'd0;
  localparam logic [2:0] REG_LEN_Y   = 3'd1;
  localparam logic [2:0] REG_LEN_Z   = 3'd2;
  localparam logic [2:0] REG_CELLS_X = 3'd3;
  localparam logic [2:0] REG_CELLS_Y = 3'd4;
  localparam logic [2:0] REG_CELLS_Z = 3'd5;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_QUERY   = 2'd1;
  localparam logic [1:0] OP_CLR_ALL = 2'd2;
  localparam logic [1:0] OP_CLR_ONE = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_WIDE = 2'd2;

  localparam logic [1:0] LAST_AXIS = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        point_id;
    logic [30:0]        search_radius;
    logic [11:0]        cell_to_clear;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] cell_index;
    logic [3:0]  id_count;
    logic [15:0] id_0;
    logic [15:0] id_1;
    logic [15:0] id_2;
    logic [15:0] id_3;
    logic [15:0] id_4;
    logic [15:0] id_5;
    logic [15:0] id_6;
    logic [15:0] id_7;
    logic        last;
  } res_t;

  // Effective geometry, shared by the front and the back.
  typedef struct packed {
    logic [LEN_W-1:0]    len_x;
    logic [LEN_W-1:0]    len_y;
    logic [LEN_W-1:0]    len_z;
    logic [N_W-1:0]      n_x;
    logic [N_W-1:0]      n_y;
    logic [N_W-1:0]      n_z;
    logic [ACTIVE_W-1:0] active;
  } geom_t;

  // One classified command, as it travels through the queue.
  typedef struct packed {
    logic [1:0]        op;
    logic              wide;
    logic [CELL_W-1:0] home;
    logic [15:0]       id;
    logic [CELL_W-1:0] clr_cell;
    logic [AXIS_W-1:0] start_x;
    logic [AXIS_W-1:0] start_y;
    logic [AXIS_W-1:0] start_z;
    logic [N_W-1:0]    span_x;
    logic [N_W-1:0]    span_y;
    logic [N_W-1:0]    span_z;
  } job_t;

  typedef enum logic [2:0] {
    FE_IDLE, FE_MOD_GO, FE_MOD_W, FE_BIN_GO, FE_BIN_W, FE_RAD_GO, FE_RAD_W, FE_PUSH
  } fe_state_t;

  typedef enum logic [3:0] {
    BE_INIT, BE_IDLE, BE_INS_RD, BE_INS_WR, BE_Q_RD, BE_Q_EMIT, BE_WIDE,
    BE_CLR_ALL, BE_CLR_ONE
  } be_state_t;

  function automatic logic [CELL_W-1:0] cell_flat(
    input logic [AXIS_W-1:0] x,
    input logic [AXIS_W-1:0] y,
    input logic [AXIS_W-1:0] z,
    input logic [N_W-1:0]    ny,
    input logic [N_W-1:0]    nz
  );
    logic [8:0] xy;
    xy = 9'(9'(x) * 9'(ny)) + 9'(y);
    return 12'(12'(xy) * 12'(nz)) + 12'(z);
  endfunction

endpackage
`default_nettype wire

// File: sv/periodic_cell_list_binner_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Periodic 3-D cell list. A command is taken when start is high and busy is
// low; every result appears for exactly one cycle with done high and cannot
// be held off, so the receiver must take each beat as it comes. Inserts and
// queries first pass through a shared restoring divider that produces one
// quotient bit per cycle: each axis needs a wrap and a binning division,
// and a query needs a third for its reach, so a query keeps the front busy
// longer than an insert before the back handles it. The back reads a query's
// visited cells one by one, each read (Q_RD) followed by its beat (Q_EMIT);
// an insert reads and then writes its home cell, a clear-one writes its
// cell and a clear-all sweeps every active cell. A two-entry queue lets the
// front classify the next command while the back is still emitting. After
// reset the fill counts are swept to zero, one cell a cycle across all 4096
// cells, and busy stays high until that pass has finished; configuration
// writes are taken throughout and must only be made while idle.
module periodic_cell_list_binner_top
  import pclb_pkg::*;
#(
  parameter int CELL_CAPACITY = 8,
  parameter int ID_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire cmd_t        cmd,
  output logic             busy,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [30:0] cfg_wdata,
  output logic             done,
  output res_t             result
);

  logic [LEN_W-1:0] len_x, len_y, len_z;
  logic [N_W-1:0]   cells_x, cells_y, cells_z;
  geom_t geom;

  logic fe_busy, be_init, take, push, pop, q_full, q_empty;
  job_t fe_job, head;

  // Register file. Lengths of zero act as one; cell counts clamp to [1, 16].
  always_ff @(posedge clk) begin
    if (rst) begin
      len_x   <= LEN_W'(65536);
      len_y   <= LEN_W'(65536);
      len_z   <= LEN_W'(65536);
      cells_x <= N_W'(1);
      cells_y <= N_W'(1);
      cells_z <= N_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LEN_X:   len_x   <= cfg_wdata;
        REG_LEN_Y:   len_y   <= cfg_wdata;
        REG_LEN_Z:   len_z   <= cfg_wdata;
        REG_CELLS_X: cells_x <= cfg_wdata[N_W-1:0];
        REG_CELLS_Y: cells_y <= cfg_wdata[N_W-1:0];
        REG_CELLS_Z: cells_z <= cfg_wdata[N_W-1:0];
        default:     cells_x <= cells_x;
      endcase
    end
  end

  function automatic logic [N_W-1:0] eff_n(input logic [N_W-1:0] c);
    if (c == '0) return N_W'(1);
    if (c > N_W'(MAX_AXIS_CELLS)) return N_W'(MAX_AXIS_CELLS);
    return c;
  endfunction

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] l);
    return (l == '0) ? LEN_W'(1) : l;
  endfunction

  always_comb begin
    geom.len_x  = eff_len(len_x);
    geom.len_y  = eff_len(len_y);
    geom.len_z  = eff_len(len_z);
    geom.n_x    = eff_n(cells_x);
    geom.n_y    = eff_n(cells_y);
    geom.n_z    = eff_n(cells_z);
    geom.active = ACTIVE_W'(ACTIVE_W'(geom.n_x) * ACTIVE_W'(geom.n_y))
                  * ACTIVE_W'(geom.n_z);
  end

  assign busy = fe_busy || be_init;
  assign take = start && !busy;

  pclb_front u_front (
    .clk(clk), .rst(rst), .take(take), .cmd(cmd), .geom(geom), .q_full(q_full),
    .busy(fe_busy), .push(push), .job(fe_job)
  );

  pclb_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wr_job(fe_job), .pop(pop),
    .head(head), .full(q_full), .empty(q_empty)
  );

  pclb_back #(
    .CELL_CAPACITY(CELL_CAPACITY), .ID_BITS(ID_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .geom(geom), .head(head), .q_empty(q_empty),
    .pop(pop), .init(be_init), .done(done), .result(result)
  );

endmodule
`default_nettype wire

// File: sv/pclb_div.sv
`timescale 1ns / 1ps
`default_nettype none
module pclb_div
  import pclb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             go,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [LEN_W-1:0] divisor,
  output logic                  done,
  output logic [DIV_W-1:0]      quot,
  output logic [LEN_W-1:0]      rem
);

  // Restoring division, one quotient bit per cycle.
  logic [DIV_CNT_W-1:0] cnt;
  logic                 running;
  logic [LEN_W:0]       trial;
  logic                 ge;

  assign trial = {rem, quot[DIV_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && (cnt == DIV_CNT_W'(1));
      if (go) begin
        running <= 1'b1;
        cnt     <= DIV_CNT_W'(DIV_W);
      end else if (running) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quot <= dividend;
      rem  <= '0;
    end else if (running) begin
      quot <= {quot[DIV_W-2:0], ge};
      rem  <= ge ? LEN_W'(trial - {1'b0, divisor}) : trial[LEN_W-1:0];
    end
  end

endmodule
`default_nettype wire

// File: sv/pclb_front.sv
`timescale 1ns / 1ps
`default_nettype none
module pclb_front
  import pclb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  take,
  input  wire cmd_t  cmd,
  input  wire geom_t geom,
  input  wire logic  q_full,
  output logic       busy,
  output logic       push,
  output job_t       job
);

  fe_state_t state, state_next;
  cmd_t      item;
  logic [1:0] axis;
  logic [LEN_W-1:0] r;
  logic [2:0][AXIS_W-1:0] b;
  logic [2:0][AXIS_W-1:0] start_a;
  logic [2:0][N_W-1:0]    span_a;
  logic wide;

  logic             div_go, div_done;
  logic [DIV_W-1:0] dividend, quot;
  logic [LEN_W-1:0] rem;
  logic signed [31:0] pos;
  logic [31:0]        mag;
  logic [LEN_W-1:0]   len;
  logic [N_W-1:0]     n;
  logic is_query;

  logic [4:0] qs;
  logic [5:0] d;
  logic [5:0] bd;
  logic       covers;

  pclb_div u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(dividend), .divisor(len),
    .done(div_done), .quot(quot), .rem(rem)
  );

  always_comb begin
    case (axis)
      2'd0: begin pos = item.pos_x; len = geom.len_x; n = geom.n_x; end
      2'd1: begin pos = item.pos_y; len = geom.len_y; n = geom.n_y; end
      default: begin pos = item.pos_z; len = geom.len_z; n = geom.n_z; end
    endcase
  end

  assign mag      = pos[31] ? 32'(-pos) : 32'(pos);
  assign is_query = item.op == OP_QUERY;

  // Reach d = 1 + floor(radius * n / len), saturated well above any axis size.
  assign qs     = (|quot[DIV_W-1:5]) ? 5'd31 : quot[4:0];
  assign d      = 6'(qs) + 6'd1;
  assign covers = {d, 1'b0} >= 7'(n);
  assign bd     = (6'(b[axis]) >= d) ? 6'(b[axis]) - d : 6'(b[axis]) + 6'(n) - d;

  always_comb begin
    state_next = state;
    case (state)
      FE_IDLE:   if (take) begin
        state_next = (cmd.op == OP_INSERT || cmd.op == OP_QUERY) ? FE_MOD_GO : FE_PUSH;
      end
      FE_MOD_GO: state_next = FE_MOD_W;
      FE_MOD_W:  if (div_done) state_next = FE_BIN_GO;
      FE_BIN_GO: state_next = FE_BIN_W;
      FE_BIN_W:  if (div_done) begin
        if (is_query) state_next = FE_RAD_GO;
        else state_next = (axis == LAST_AXIS) ? FE_PUSH : FE_MOD_GO;
      end
      FE_RAD_GO: state_next = FE_RAD_W;
      FE_RAD_W:  if (div_done) state_next = (axis == LAST_AXIS) ? FE_PUSH : FE_MOD_GO;
      FE_PUSH:   if (!q_full) state_next = FE_IDLE;
      default:   state_next = FE_IDLE;
    endcase
  end

  always_comb begin
    div_go   = 1'b0;
    dividend = DIV_W'(mag);
    push     = 1'b0;
    case (state)
      FE_MOD_GO: div_go = 1'b1;
      FE_BIN_GO: begin
        div_go   = 1'b1;
        dividend = DIV_W'(DIV_W'(r) * DIV_W'(n));
      end
      FE_RAD_GO: begin
        div_go   = 1'b1;
        dividend = DIV_W'(DIV_W'(item.search_radius) * DIV_W'(n));
      end
      FE_PUSH:   push = !q_full;
      default:   div_go = 1'b0;
    endcase
  end

  assign busy = state != FE_IDLE;

  always_comb begin
    job.op       = item.op;
    job.wide     = wide;
    job.home     = cell_flat(b[0], b[1], b[2], geom.n_y, geom.n_z);
    job.id       = item.point_id;
    job.clr_cell = item.cell_to_clear;
    job.start_x  = start_a[0];
    job.start_y  = start_a[1];
    job.start_z  = start_a[2];
    job.span_x   = span_a[0];
    job.span_y   = span_a[1];
    job.span_z   = span_a[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == FE_IDLE && take) begin
      item <= cmd;
      axis <= '0;
      wide <= 1'b0;
    end
    if (state == FE_MOD_W && div_done) begin
      r <= (pos[31] && rem != '0) ? len - rem : rem;
    end
    if (state == FE_BIN_W && div_done) begin
      b[axis] <= (quot >= DIV_W'(n)) ? AXIS_W'(n - N_W'(1)) : quot[AXIS_W-1:0];
      if (!is_query && axis != LAST_AXIS) axis <= axis + 2'd1;
    end
    if (state == FE_RAD_W && div_done) begin
      start_a[axis] <= covers ? '0 : AXIS_W'(bd);
      span_a[axis]  <= covers ? n : N_W'({d, 1'b0} + 7'd1);
      if (qs != '0 && n > WIDE_AXIS) wide <= 1'b1;
      if (axis != LAST_AXIS) axis <= axis + 2'd1;
    end
  end

endmodule
`default_nettype wire

// File: sv/pclb_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module pclb_queue
  import pclb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t wr_job,
  input  wire logic pop,
  output job_t      head,
  output logic      full,
  output logic      empty
);

  job_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign head  = slots[rd_ptr];
  assign full  = count == 2'd2;
  assign empty = count == 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_job;
  end

endmodule
`default_nettype wire

// File: sv/pclb_back.sv
`timescale 1ns / 1ps
`default_nettype none
module pclb_back
  import pclb_pkg::*;
#(
  parameter int CELL_CAPACITY = 8,
  parameter int ID_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire geom_t geom,
  input  wire job_t  head,
  input  wire logic  q_empty,
  output logic       pop,
  output logic       init,
  output logic       done,
  output res_t       result
);

  localparam int FILL_W = $clog2(CELL_CAPACITY + 1);
  localparam int SLOT_W = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;

  logic [FILL_W-1:0]  fill_mem [NUM_CELLS];
  logic [ID_BITS-1:0] id_mem   [NUM_CELLS][CELL_CAPACITY];

  be_state_t state, state_next;
  job_t      job;
  logic [CELL_W-1:0] sweep;
  logic [N_W-1:0]    cx, cy, cz;
  logic [AXIS_W-1:0] tx, ty, tz;

  logic [FILL_W-1:0]  rd_fill;
  logic [ID_BITS-1:0] rd_row [CELL_CAPACITY];

  logic              fill_we, id_we;
  logic [CELL_W-1:0] waddr, raddr;
  logic [FILL_W-1:0] fill_wdata;
  logic              room, ins_mode, walk_last, sweep_end;
  logic [CELL_W-1:0] walk_cell;
  logic [3:0]        show_cnt;
  logic [ID_BITS-1:0] slot_id [OUT_IDS];
  logic [15:0]       shown [OUT_IDS];
  logic              emit;
  res_t              emit_res;

  function automatic logic [AXIS_W-1:0] inc_wrap(
    input logic [AXIS_W-1:0] t,
    input logic [N_W-1:0]    n
  );
    return (N_W'(t) + N_W'(1) == n) ? '0 : t + AXIS_W'(1);
  endfunction

  assign room      = rd_fill < FILL_W'(CELL_CAPACITY);
  assign ins_mode  = state == BE_INS_WR && room;
  assign walk_cell = cell_flat(tx, ty, tz, geom.n_y, geom.n_z);
  assign walk_last = cx == job.span_x - N_W'(1) && cy == job.span_y - N_W'(1)
                     && cz == job.span_z - N_W'(1);
  assign sweep_end = {1'b0, sweep} == geom.active - ACTIVE_W'(1);
  assign pop       = state == BE_IDLE && !q_empty;
  assign init      = state == BE_INIT;

  // The row as shown: on an insert with room the new id sits in its slot.
  for (genvar j = 0; j < OUT_IDS; j++) begin : g_ids
    if (j < CELL_CAPACITY) begin : g_on
      assign slot_id[j] = (ins_mode && SLOT_W'(j) == SLOT_W'(rd_fill))
                          ? ID_BITS'(job.id) : rd_row[j];
    end else begin : g_off
      assign slot_id[j] = '0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      BE_INIT:    if (sweep == CELL_W'(NUM_CELLS - 1)) state_next = BE_IDLE;
      BE_IDLE:    if (!q_empty) begin
        case (head.op)
          OP_INSERT: state_next = BE_INS_RD;
          OP_QUERY:  state_next = head.wide ? BE_WIDE : BE_Q_RD;
          OP_CLR_ALL: state_next = BE_CLR_ALL;
          default:   state_next = BE_CLR_ONE;
        endcase
      end
      BE_INS_RD:  state_next = BE_INS_WR;
      BE_INS_WR:  state_next = BE_IDLE;
      BE_Q_RD:    state_next = BE_Q_EMIT;
      BE_Q_EMIT:  state_next = walk_last ? BE_IDLE : BE_Q_RD;
      BE_WIDE:    state_next = BE_IDLE;
      BE_CLR_ALL: if (sweep_end) state_next = BE_IDLE;
      BE_CLR_ONE: state_next = BE_IDLE;
      default:    state_next = BE_IDLE;
    endcase
  end

  always_comb begin
    fill_we    = 1'b0;
    id_we      = 1'b0;
    waddr      = sweep;
    fill_wdata = '0;
    raddr      = job.home;
    emit       = 1'b0;
    show_cnt   = '0;
    emit_res   = '0;
    emit_res.last = 1'b1;
    case (state)
      BE_INIT: fill_we = 1'b1;
      BE_INS_WR: begin
        emit = 1'b1;
        emit_res.cell_index = job.home;
        if (room) begin
          fill_we    = 1'b1;
          id_we      = 1'b1;
          waddr      = job.home;
          fill_wdata = rd_fill + FILL_W'(1);
          show_cnt   = 4'(rd_fill) + 4'd1;
          emit_res.status = ST_OK;
        end else begin
          show_cnt   = 4'(rd_fill);
          emit_res.status = ST_FULL;
        end
      end
      BE_Q_RD: raddr = walk_cell;
      BE_Q_EMIT: begin
        emit     = 1'b1;
        show_cnt = 4'(rd_fill);
        emit_res.cell_index = walk_cell;
        emit_res.last       = walk_last;
      end
      BE_WIDE: begin
        emit = 1'b1;
        emit_res.status     = ST_WIDE;
        emit_res.cell_index = job.home;
      end
      BE_CLR_ALL: begin
        fill_we = 1'b1;
        emit    = sweep_end;
      end
      BE_CLR_ONE: begin
        fill_we = {1'b0, job.clr_cell} < geom.active;
        waddr   = job.clr_cell;
        emit    = 1'b1;
        emit_res.cell_index = job.clr_cell;
      end
      default: emit = 1'b0;
    endcase
    for (int k = 0; k < OUT_IDS; k++) begin
      shown[k] = (4'(k) < show_cnt) ? 16'(slot_id[k]) : 16'd0;
    end
    emit_res.id_count = show_cnt;
    emit_res.id_0 = shown[0];
    emit_res.id_1 = shown[1];
    emit_res.id_2 = shown[2];
    emit_res.id_3 = shown[3];
    emit_res.id_4 = shown[4];
    emit_res.id_5 = shown[5];
    emit_res.id_6 = shown[6];
    emit_res.id_7 = shown[7];
  end

  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[waddr] <= fill_wdata;
    if (id_we) id_mem[waddr][SLOT_W'(rd_fill)] <= ID_BITS'(job.id);
    rd_fill <= fill_mem[raddr];
    rd_row  <= id_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BE_INIT;
      sweep <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= emit;
      if (state == BE_INIT || state == BE_CLR_ALL) sweep <= sweep + CELL_W'(1);
      else sweep <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) result <= emit_res;
    if (pop) begin
      job <= head;
      cx  <= '0;
      cy  <= '0;
      cz  <= '0;
      tx  <= head.start_x;
      ty  <= head.start_y;
      tz  <= head.start_z;
    end else if (state == BE_Q_EMIT) begin
      if (cz != job.span_z - N_W'(1)) begin
        cz <= cz + N_W'(1);
        tz <= inc_wrap(tz, geom.n_z);
      end else begin
        cz <= '0;
        tz <= job.start_z;
        if (cy != job.span_y - N_W'(1)) begin
          cy <= cy + N_W'(1);
          ty <= inc_wrap(ty, geom.n_y);
        end else begin
          cy <= '0;
          ty <= job.start_y;
          cx <= cx + N_W'(1);
          tx <= inc_wrap(tx, geom.n_x);
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/pclb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module pclb_props
  import pclb_pkg::*;
#(
  parameter int CELL_CAPACITY = 8
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire res_t result
);

  // Coming out of reset the block sweeps its fill counts and shows nothing.
  a_reset: assert property (@(posedge clk) rst |=> busy && !done)
    else $error("block not busy or emitting right after reset");

  a_take: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("command taken but block did not turn busy");

  a_wide: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_WIDE |-> result.last && result.id_count == 4'd0)
    else $error("wide-search beat malformed");

  a_full: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_FULL |-> result.last
      && result.id_count == 4'(CELL_CAPACITY))
    else $error("cell-full beat malformed");

  a_count: assert property (@(posedge clk) disable iff (rst)
    done |-> result.id_count <= 4'(CELL_CAPACITY))
    else $error("id count above capacity");

endmodule

bind periodic_cell_list_binner_top pclb_props #(
  .CELL_CAPACITY(CELL_CAPACITY)
) u_pclb_props (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .result(result)
);
`default_nettype wire
